// ===== rtl/mbfb_pkg.sv =====
// Shared types and constants for the MSB-first bit-field buffer.
// No dependencies; imported by the top level.
package mbfb_pkg;

   localparam int OFF_W      = 11;  // bit offset width
   localparam int LEN_W      = 7;   // field length width
   localparam int WORD_W     = 64;  // storage word, eight bytes MSB first
   localparam int WSEL_W     = 6;   // bit position inside a word
   localparam int BIDX_W     = OFF_W - WSEL_W;  // word address / bank index width
   localparam int MAX_LEN    = 64;
   localparam int MAX_SLEN   = 32;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_GET_U = 2'd1,
      CMD_GET_S = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_RANGE  = 2'd1,
      STAT_LENGTH = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // decoded word, held from accept through the execute cycle
   typedef struct packed {
      logic              is_put;
      logic              is_signed;
      logic              do_op;
      logic [LEN_W-1:0]  field_len;
      logic [WSEL_W-1:0] word_off;
      logic              odd_first;
      logic              ev_ok;
      logic              od_ok;
      status_type        status;
   } op_type;

endpackage

// ===== rtl/mbfb_bank_ram.sv =====
// One storage bank: single write port, single read port, registered read.
// Standalone; no package dependency.
module mbfb_bank_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/msb_first_bit_field_buffer.sv =====
// Top level of the MSB-first bit-field buffer: decode, field shifting and merge.
// Depends on mbfb_pkg and mbfb_bank_ram.
//
// The buffer holds BUF_BYTES bytes in network bit order (position 0 is the MSB
// of byte 0). Storage is 64-bit words split over an even and an odd bank, so
// any field of up to 64 bits touches at most two adjacent words, one per bank.
// A command word is taken when start is high and busy is low. It is read at
// the accept edge, shifted and merged in the next cycle, written back at the
// end of that cycle, and its result is registered onto the rsp_ ports, with
// rsp_valid high for a single cycle. The registered read followed by the
// write-back of the same words sets the rate: busy is high while a command
// executes, so a new word is not taken until the previous one has been
// written back. The receiver cannot stall results. After reset the block
// clears both banks, one word per bank each cycle; busy stays high during
// that pass.
module msb_first_bit_field_buffer #(
   parameter int BUF_BYTES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_cmd,
   input  logic [mbfb_pkg::OFF_W-1:0]   req_bit_offset,
   input  logic [mbfb_pkg::LEN_W-1:0]   req_field_len,
   input  logic [mbfb_pkg::WORD_W-1:0]  req_write_value,
   output logic                         rsp_valid,
   output logic [mbfb_pkg::WORD_W-1:0]  rsp_read_data,
   output logic [mbfb_pkg::LEN_W-1:0]   rsp_bits_done,
   output logic [1:0]                   rsp_status
);

   import mbfb_pkg::*;

   localparam int NUM_WORDS  = (BUF_BYTES + 7) / 8;
   localparam int BANK_DEPTH = (NUM_WORDS + 1) / 2;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int BUF_BITS   = 8 * BUF_BYTES;

   // ---------------------------------------------------------------
   // control state
   // ---------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [BANK_AW-1:0]   clr_idx_ff, clr_idx_in;
   logic                 accept;
   logic                 clearing;
   logic                 executing;

   // decoded command and aligned put data, captured at accept
   op_type               op_ff, op_in;
   logic [BANK_AW-1:0]   ev_addr_ff, od_addr_ff;
   logic [2*WORD_W-1:0]  put_data_ff, put_data_in;
   logic [2*WORD_W-1:0]  put_mask_ff, put_mask_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [LEN_W-1:0]     rsp_done_ff, rsp_done_in;
   status_type           rsp_status_ff, rsp_status_in;

   // ---------------------------------------------------------------
   // decode at accept
   // ---------------------------------------------------------------
   cmd_type              cmd;
   logic [LEN_W-1:0]     len_limit;
   logic                 is_nop, len_bad, range_bad;
   logic [OFF_W:0]       end_pos;
   logic [BIDX_W-1:0]    word_addr;
   logic [BIDX_W-1:0]    ev_idx, od_idx;
   logic [WORD_W-1:0]    len_mask, top_val, top_mask;
   logic [LEN_W-1:0]     top_shift;
   logic [WSEL_W-1:0]    req_word_off;

   assign accept = start && !busy;
   assign cmd    = cmd_type'(req_cmd);

   always_comb begin
      len_limit = (cmd == CMD_GET_S) ? LEN_W'(MAX_SLEN) : LEN_W'(MAX_LEN);
      is_nop    = (cmd == CMD_NOP) || (req_field_len == '0);
      len_bad   = req_field_len > len_limit;
      end_pos   = (OFF_W+1)'(req_bit_offset) + (OFF_W+1)'(req_field_len);
      range_bad = 32'(end_pos) > 32'(BUF_BITS);

      // first word goes to its own bank; the following word to the other one
      word_addr    = req_bit_offset[OFF_W-1:WSEL_W];
      req_word_off = req_bit_offset[WSEL_W-1:0];
      od_idx       = {1'b0, word_addr[BIDX_W-1:1]};
      ev_idx       = {1'b0, word_addr[BIDX_W-1:1]} + BIDX_W'(word_addr[0]);

      op_in.is_put    = (cmd == CMD_PUT);
      op_in.is_signed = (cmd == CMD_GET_S);
      op_in.do_op     = !is_nop && !len_bad && !range_bad;
      op_in.field_len = req_field_len;
      op_in.word_off  = req_word_off;
      op_in.odd_first = word_addr[0];
      op_in.ev_ok     = 32'(ev_idx) < 32'(BANK_DEPTH);
      op_in.od_ok     = 32'(od_idx) < 32'(BANK_DEPTH);
      if (is_nop) begin
         op_in.status = STAT_OK;
      end else if (len_bad) begin
         op_in.status = STAT_LENGTH;
      end else if (range_bad) begin
         op_in.status = STAT_RANGE;
      end else begin
         op_in.status = STAT_OK;
      end

      // put value: low field_len bits, left-aligned then moved to the bit offset
      len_mask    = ~({WORD_W{1'b1}} << req_field_len);
      top_shift   = LEN_W'(WORD_W) - req_field_len;
      top_val     = (req_write_value & len_mask) << top_shift;
      top_mask    = len_mask << top_shift;
      put_data_in = {top_val, {WORD_W{1'b0}}} >> req_word_off;
      put_mask_in = {top_mask, {WORD_W{1'b0}}} >> req_word_off;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= op_in;
         ev_addr_ff  <= BANK_AW'(ev_idx);
         od_addr_ff  <= BANK_AW'(od_idx);
         put_data_ff <= put_data_in;
         put_mask_ff <= put_mask_in;
      end
   end

   // ---------------------------------------------------------------
   // storage banks
   // ---------------------------------------------------------------
   logic                 ev_wr_en, od_wr_en;
   logic [BANK_AW-1:0]   ev_wr_addr, od_wr_addr;
   logic [WORD_W-1:0]    ev_wr_data, od_wr_data;
   logic [WORD_W-1:0]    ev_rd_data, od_rd_data;

   mbfb_bank_ram #(
      .DEPTH (BANK_DEPTH),
      .AW    (BANK_AW),
      .WIDTH (WORD_W)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (ev_wr_en),
      .wr_addr (ev_wr_addr),
      .wr_data (ev_wr_data),
      .rd_en   (accept),
      .rd_addr (BANK_AW'(ev_idx)),
      .rd_data (ev_rd_data)
   );

   mbfb_bank_ram #(
      .DEPTH (BANK_DEPTH),
      .AW    (BANK_AW),
      .WIDTH (WORD_W)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (od_wr_en),
      .wr_addr (od_wr_addr),
      .wr_data (od_wr_data),
      .rd_en   (accept),
      .rd_addr (BANK_AW'(od_idx)),
      .rd_data (od_rd_data)
   );

   // ---------------------------------------------------------------
   // execute: extract, sign-extend, merge
   // ---------------------------------------------------------------
   logic [WORD_W-1:0]    ev_word, od_word, hi_word, lo_word;
   logic [2*WORD_W-1:0]  pair, pair_shl, pair_new;
   logic [WORD_W-1:0]    window, field, sign_ext;
   logic [WORD_W-1:0]    new_hi, new_lo;
   logic                 wr_ok;

   always_comb begin
      ev_word  = op_ff.ev_ok ? ev_rd_data : '0;
      od_word  = op_ff.od_ok ? od_rd_data : '0;
      hi_word  = op_ff.odd_first ? od_word : ev_word;
      lo_word  = op_ff.odd_first ? ev_word : od_word;
      pair     = {hi_word, lo_word};

      // window's MSB is the field's first bit
      pair_shl = pair << op_ff.word_off;
      window   = pair_shl[2*WORD_W-1:WORD_W];
      field    = window >> (LEN_W'(WORD_W) - op_ff.field_len);
      sign_ext = {WORD_W{1'b1}} << WSEL_W'(op_ff.field_len - LEN_W'(1));
      if (op_ff.is_signed && window[WORD_W-1]) begin
         field = field | sign_ext;
      end

      pair_new = (pair & ~put_mask_ff) | (put_data_ff & put_mask_ff);
      new_hi   = pair_new[2*WORD_W-1:WORD_W];
      new_lo   = pair_new[WORD_W-1:0];
      wr_ok    = executing && op_ff.is_put && op_ff.do_op;

      if (clearing) begin
         ev_wr_en   = 1'b1;
         od_wr_en   = 1'b1;
         ev_wr_addr = clr_idx_ff;
         od_wr_addr = clr_idx_ff;
         ev_wr_data = '0;
         od_wr_data = '0;
      end else begin
         ev_wr_en   = wr_ok && op_ff.ev_ok;
         od_wr_en   = wr_ok && op_ff.od_ok;
         ev_wr_addr = ev_addr_ff;
         od_wr_addr = od_addr_ff;
         ev_wr_data = op_ff.odd_first ? new_lo : new_hi;
         od_wr_data = op_ff.odd_first ? new_hi : new_lo;
      end

      rsp_valid_in  = executing;
      rsp_data_in   = (op_ff.do_op && !op_ff.is_put) ? field : '0;
      rsp_done_in   = op_ff.do_op ? op_ff.field_len : '0;
      rsp_status_in = op_ff.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (executing) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_done_ff   <= rsp_done_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_bits_done = rsp_done_ff;
   assign rsp_status    = rsp_status_ff;

   // ---------------------------------------------------------------
   // sequencer: clear pass, then idle/execute
   // ---------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + BANK_AW'(1);
            if (clr_idx_ff == BANK_AW'(BANK_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      clearing  = 1'b0;
      executing = 1'b0;
      busy      = 1'b1;
      case (state_ff)
         ST_CLEAR: clearing  = 1'b1;
         ST_IDLE:  busy      = 1'b0;
         ST_EXEC:  executing = 1'b1;
         default:  busy      = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   a_rsp_two_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("result strobe missing two cycles after accept");

   a_error_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> (rsp_bits_done == '0 && rsp_read_data == '0))
      else $error("error result carries data");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!ev_wr_en && !od_wr_en))
      else $error("bank write outside clear or execute");

   a_ready_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while a result is shown");

endmodule
